[rtl/assert_macros.svh]
// assertion macros shared by the quantile filter rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, off while reset is low
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[rtl/cqfl_pkg.sv]
// widths, register codes, types and helper functions of the quantile filter
// no dependencies
`default_nettype none

package cqfl_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned TAU_W      = 17;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned LOSS_W     = 47;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned MUL_W      = 34;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned RND_SHIFT  = 16;
  localparam int unsigned RND_W      = PROD_W - RND_SHIFT;
  localparam int unsigned ACC_W      = 51;
  localparam int unsigned TERM_W     = 34;
  localparam int unsigned MAX_TAPS   = 2;
  localparam int unsigned AR_TAPS_DEF  = 2;
  localparam int unsigned LAG_TAPS_DEF = 2;

  localparam logic [TAU_W-1:0]  ONE_Q16   = TAU_W'(65536);
  localparam logic [TAU_W-1:0]  TAU_RESET = TAU_W'(32768);
  localparam logic [CNT_W-1:0]  WARM_RESET = CNT_W'(2);
  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [LOSS_W-1:0] LOSS_MAX  = {LOSS_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AR_FIRST   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_AR_SECOND  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LAG_FIRST  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LAG_SECOND = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TAU        = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_START_Q    = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP     = CFG_IDX_W'(7);

  typedef struct packed {
    logic signed [DATA_W-1:0] intercept;
    logic signed [DATA_W-1:0] ar_weight_first;
    logic signed [DATA_W-1:0] ar_weight_second;
    logic signed [DATA_W-1:0] lag_weight_first;
    logic signed [DATA_W-1:0] lag_weight_second;
    logic        [TAU_W-1:0]  quantile_level;
    logic signed [DATA_W-1:0] start_quantile;
    logic        [CNT_W-1:0]  warmup_count;
  } cfg_t;

  typedef struct packed {
    logic                    vld;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    vld;
    logic signed [RND_W-1:0] rnd;
  } mul_rsp_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/cqfl_if.sv]
// valid/ready channels of the quantile filter: input item, result item, register write
// depends on cqfl_pkg
`default_nettype none

interface cqfl_item_if;
  import cqfl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] observation;
  logic signed [DATA_W-1:0] lag_value_first;
  logic signed [DATA_W-1:0] lag_value_second;
  logic signed [DATA_W-1:0] warmup_value;
  logic                     last_item;

  modport source (output valid, observation, lag_value_first, lag_value_second,
                  warmup_value, last_item, input ready);
  modport sink (input valid, observation, lag_value_first, lag_value_second,
                warmup_value, last_item, output ready);
endinterface

interface cqfl_result_if;
  import cqfl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] quantile_value;
  logic        [LOSS_W-1:0] running_loss;
  logic                     in_warmup;

  modport source (output valid, quantile_value, running_loss, in_warmup, input ready);
  modport sink (input valid, quantile_value, running_loss, in_warmup, output ready);
endinterface

interface cqfl_cfg_if;
  import cqfl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/cqfl_cfg.sv]
// configuration register file of the quantile filter
// depends on cqfl_pkg and cqfl_if
`default_nettype none

module cqfl_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  cqfl_cfg_if.sink      cfg_i,
  output cqfl_pkg::cfg_t cfg_o
);
  import cqfl_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_INTERCEPT:  cfg_d.intercept         = cfg_i.data;
        REG_AR_FIRST:   cfg_d.ar_weight_first   = cfg_i.data;
        REG_AR_SECOND:  cfg_d.ar_weight_second  = cfg_i.data;
        REG_LAG_FIRST:  cfg_d.lag_weight_first  = cfg_i.data;
        REG_LAG_SECOND: cfg_d.lag_weight_second = cfg_i.data;
        REG_TAU:        cfg_d.quantile_level    = cfg_i.data[TAU_W-1:0];
        REG_START_Q:    cfg_d.start_quantile    = cfg_i.data;
        REG_WARMUP:     cfg_d.warmup_count      = cfg_i.data[CNT_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.intercept         <= '0;
      cfg_q.ar_weight_first   <= '0;
      cfg_q.ar_weight_second  <= '0;
      cfg_q.lag_weight_first  <= '0;
      cfg_q.lag_weight_second <= '0;
      cfg_q.quantile_level    <= TAU_RESET;
      cfg_q.start_quantile    <= '0;
      cfg_q.warmup_count      <= WARM_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[rtl/cqfl_mul.sv]
// shared signed multiplier with round-half-up shift by 16, one register stage
// depends on cqfl_pkg
`default_nettype none

module cqfl_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cqfl_pkg::mul_req_t req_i,
  output cqfl_pkg::mul_rsp_t rsp_o
);
  import cqfl_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.vld) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  // floor(p / 2^16) plus the half bit
  assign rsp_o.vld = vld_q;
  assign rsp_o.rnd = $signed(prod_q[PROD_W-1:RND_SHIFT])
                   + $signed({{(RND_W-1){1'b0}}, prod_q[RND_SHIFT-1]});

endmodule

`default_nettype wire

[rtl/caviar_quantile_filter_loss.sv]
// top level of the recursive quantile filter with pinball loss, sequencer and datapath
// depends on cqfl_pkg, cqfl_if, cqfl_cfg, cqfl_mul and assert_macros.svh
//
// channel   | dir | handshake     | payload
// item_i    | in  | valid / ready | observation, lag values, warmup_value, last_item
// result_o  | out | valid / ready | quantile_value, running_loss, in_warmup
// cfg_i     | in  | valid / ready | index, data
//
// an item passes from its accept through S_MUL, where the single multiplier does each
// tap product, one per cycle, then S_SAT, S_RES with the loss product, S_LOSS and S_OUT
// back to S_IDLE for the next accept when the recursion runs; in warm-up it skips S_MUL
// a result waits in its register until taken; a result stall delays the next accept
// reset clears the filter state and loads the register defaults; cfg_i is always ready
`default_nettype none
`include "assert_macros.svh"

module caviar_quantile_filter_loss #(
  parameter int unsigned AR_TAPS  = cqfl_pkg::AR_TAPS_DEF,
  parameter int unsigned LAG_TAPS = cqfl_pkg::LAG_TAPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cqfl_item_if.sink    item_i,
  cqfl_result_if.source result_o,
  cqfl_cfg_if.sink     cfg_i
);
  import cqfl_pkg::*;

  localparam int unsigned NUM_TAPS = AR_TAPS + LAG_TAPS;
  localparam int unsigned IDX_W    = $clog2(NUM_TAPS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SAT  = 3'd2;
  localparam logic [2:0] S_RES  = 3'd3;
  localparam logic [2:0] S_LOSS = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] lag_idx;

  logic signed [DATA_W-1:0] past_q [MAX_TAPS];
  logic        [CNT_W-1:0]  count_q;
  logic        [LOSS_W-1:0] loss_q;

  logic signed [DATA_W-1:0] obs_q, lag1_q, lag2_q;
  logic                     last_q, warm_flag_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [DATA_W-1:0] est_q;

  logic signed [DATA_W-1:0] res_val_q;
  logic        [LOSS_W-1:0] res_loss_q;
  logic                     res_warm_q;

  logic                     item_acc;
  logic                     res_acc;
  logic                     warm_now;
  logic signed [DATA_W:0]   resid;
  logic        [DATA_W:0]   mag;
  logic        [TAU_W-1:0]  tau;
  logic        [TAU_W-1:0]  wgt;
  logic        [TERM_W-1:0] term;
  logic        [LOSS_W:0]   loss_sum;
  logic        [LOSS_W-1:0] loss_new;

  cqfl_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  cqfl_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign item_i.ready = (state_q == S_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign result_o.valid          = (state_q == S_OUT);
  assign result_o.quantile_value = res_val_q;
  assign result_o.running_loss   = res_loss_q;
  assign result_o.in_warmup      = res_warm_q;
  assign res_acc = result_o.valid && result_o.ready;

  assign warm_now = count_q < cfg.warmup_count;
  assign lag_idx  = idx_q - IDX_W'(AR_TAPS);

  // loss weight and residual magnitude
  assign tau   = (cfg.quantile_level > ONE_Q16) ? ONE_Q16 : cfg.quantile_level;
  assign resid = (DATA_W+1)'(obs_q) - (DATA_W+1)'(est_q);
  assign mag   = resid[DATA_W] ? (DATA_W+1)'(-resid) : (DATA_W+1)'(resid);
  always_comb begin
    if (resid > 0) begin
      wgt = tau;
    end else if (resid < 0) begin
      wgt = ONE_Q16 - tau;
    end else begin
      wgt = '0;
    end
  end

  assign term     = mul_rsp.rnd[TERM_W-1:0];
  assign loss_sum = {1'b0, loss_q} + (LOSS_W+1)'(term);
  assign loss_new = (loss_sum > (LOSS_W+1)'(LOSS_MAX)) ? LOSS_MAX : loss_sum[LOSS_W-1:0];

  // operand select for the shared multiplier
  always_comb begin
    mul_req = '0;
    case (state_q)
      S_MUL: begin
        if (idx_q != IDX_W'(NUM_TAPS)) begin
          mul_req.vld = 1'b1;
          if (idx_q < IDX_W'(AR_TAPS)) begin
            mul_req.a = idx_q[0] ? MUL_W'(cfg.ar_weight_second)
                                 : MUL_W'(cfg.ar_weight_first);
            mul_req.b = MUL_W'(past_q[idx_q[0]]);
          end else begin
            mul_req.a = lag_idx[0] ? MUL_W'(cfg.lag_weight_second)
                                   : MUL_W'(cfg.lag_weight_first);
            mul_req.b = lag_idx[0] ? MUL_W'(lag2_q) : MUL_W'(lag1_q);
          end
        end
      end
      S_RES: begin
        mul_req.vld = 1'b1;
        mul_req.a   = $signed({{(MUL_W-TAU_W){1'b0}}, wgt});
        mul_req.b   = $signed({{(MUL_W-DATA_W-1){1'b0}}, mag});
      end
      default: mul_req = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    case (state_q)
      S_IDLE: begin
        if (item_acc) begin
          idx_d = '0;
          if (warm_now) begin
            acc_d   = ACC_W'(item_i.warmup_value) + ACC_W'(cfg.start_quantile);
            state_d = S_SAT;
          end else begin
            acc_d   = ACC_W'(cfg.intercept);
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (idx_q != IDX_W'(NUM_TAPS)) begin
          idx_d = idx_q + IDX_W'(1);
        end else begin
          state_d = S_SAT;
        end
        if (mul_rsp.vld) begin
          acc_d = acc_q + ACC_W'(mul_rsp.rnd);
        end
      end
      S_SAT:   state_d = S_RES;
      S_RES:   state_d = S_LOSS;
      S_LOSS:  state_d = S_OUT;
      S_OUT: begin
        if (res_acc) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      count_q   <= '0;
      loss_q    <= '0;
      past_q[0] <= '0;
      past_q[1] <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (state_q == S_LOSS) begin
        if (last_q) begin
          count_q   <= '0;
          loss_q    <= '0;
          past_q[0] <= '0;
          past_q[1] <= '0;
        end else begin
          loss_q    <= loss_new;
          past_q[0] <= est_q;
          past_q[1] <= past_q[0];
          if (count_q != CNT_MAX) begin
            count_q <= count_q + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (item_acc) begin
      obs_q       <= item_i.observation;
      lag1_q      <= item_i.lag_value_first;
      lag2_q      <= item_i.lag_value_second;
      last_q      <= item_i.last_item;
      warm_flag_q <= warm_now;
    end
    if (state_q == S_SAT) begin
      est_q <= sat32(acc_q);
    end
    if (state_q == S_LOSS) begin
      res_val_q  <= est_q;
      res_loss_q <= loss_new;
      res_warm_q <= warm_flag_q;
    end
  end

  `ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, item_acc |=> !item_i.ready)
  `ASSERT_RST(a_no_take_while_held, clk_i, rst_ni, result_o.valid |-> !item_i.ready)
  `ASSERT_RST(a_mul_rsp_slot, clk_i, rst_ni,
              mul_rsp.vld |-> (state_q == S_MUL || state_q == S_LOSS))
  `ASSERT_RST(a_ready_after_result, clk_i, rst_ni, res_acc |=> item_i.ready)
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !result_o.valid)

endmodule

`default_nettype wire

[tb/cqfl_result_check.sv]
// result checker of the quantile filter: keeps its own copy of the registers and the
// series state, predicts every result item and compares it with the result channel
// depends on cqfl_pkg and cqfl_if
`default_nettype none

module cqfl_result_check #(
  parameter int unsigned AR_TAPS  = cqfl_pkg::AR_TAPS_DEF,
  parameter int unsigned LAG_TAPS = cqfl_pkg::LAG_TAPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cqfl_item_if        item_mon,
  cqfl_result_if      result_mon,
  cqfl_cfg_if         cfg_mon,
  output int unsigned error_count_o,
  output int unsigned pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cqfl_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] quantile_value;
    logic        [LOSS_W-1:0] running_loss;
    logic                     in_warmup;
  } estimate_t;

  cfg_t                     settings;
  logic signed [DATA_W-1:0] past_est [MAX_TAPS];
  logic        [CNT_W-1:0]  series_count;
  longint unsigned          loss_acc;
  estimate_t                estimate_queue [$];

  function automatic longint round_product(input longint a, input longint b);
    return (a * b + 64'sd32768) >>> RND_SHIFT;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic estimate_t filter_step(input logic signed [DATA_W-1:0] obs,
                                            input logic signed [DATA_W-1:0] lag1,
                                            input logic signed [DATA_W-1:0] lag2,
                                            input logic signed [DATA_W-1:0] warm,
                                            input logic last_flag);
    estimate_t                e;
    logic signed [DATA_W-1:0] est;
    logic        [TAU_W-1:0]  tau;
    logic                     warming;
    longint                   acc;
    longint                   resid;
    longint unsigned          w;
    longint unsigned          mag;
    longint unsigned          term;
    warming = series_count < settings.warmup_count;
    tau = (settings.quantile_level > ONE_Q16) ? ONE_Q16 : settings.quantile_level;
    if (warming) begin
      acc = longint'(warm) + longint'($signed(settings.start_quantile));
    end else begin
      acc = longint'($signed(settings.intercept));
      acc += round_product($signed(settings.ar_weight_first), past_est[0]);
      if (AR_TAPS >= 2) begin
        acc += round_product($signed(settings.ar_weight_second), past_est[1]);
      end
      acc += round_product($signed(settings.lag_weight_first), lag1);
      if (LAG_TAPS >= 2) begin
        acc += round_product($signed(settings.lag_weight_second), lag2);
      end
    end
    est = clamp32(acc);
    resid = longint'(obs) - longint'(est);
    if (resid > 0) begin
      w = 64'(tau);
      mag = resid;
    end else if (resid < 0) begin
      w = 64'(ONE_Q16) - 64'(tau);
      mag = -resid;
    end else begin
      w = 0;
      mag = 0;
    end
    term = (w * mag + 64'd32768) >> RND_SHIFT;
    if (term > 64'(LOSS_MAX) - loss_acc) begin
      loss_acc = 64'(LOSS_MAX);
    end else begin
      loss_acc += term;
    end
    e.quantile_value = est;
    e.running_loss = loss_acc[LOSS_W-1:0];
    e.in_warmup = warming;
    past_est[1] = past_est[0];
    past_est[0] = est;
    if (series_count != CNT_MAX) begin
      series_count++;
    end
    if (last_flag) begin
      past_est[0] = '0;
      past_est[1] = '0;
      series_count = '0;
      loss_acc = 0;
    end
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t want;
    if (!rst_ni) begin
      settings = '0;
      settings.quantile_level = TAU_RESET;
      settings.warmup_count = WARM_RESET;
      past_est[0] = '0;
      past_est[1] = '0;
      series_count = '0;
      loss_acc = 0;
      estimate_queue.delete();
      error_count_o = 0;
      pending_count_o = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (estimate_queue.size() == 0) begin
          $error("result item with no item pending: quantile_value %0d",
                 result_mon.quantile_value);
          error_count_o++;
        end else begin
          want = estimate_queue.pop_front();
          if (result_mon.quantile_value !== want.quantile_value) begin
            $error("quantile_value: expected %0d, actual %0d",
                   want.quantile_value, result_mon.quantile_value);
            error_count_o++;
          end
          if (result_mon.running_loss !== want.running_loss) begin
            $error("running_loss: expected %0d, actual %0d",
                   want.running_loss, result_mon.running_loss);
            error_count_o++;
          end
          if (result_mon.in_warmup !== want.in_warmup) begin
            $error("in_warmup: expected %0d, actual %0d",
                   want.in_warmup, result_mon.in_warmup);
            error_count_o++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_INTERCEPT:  settings.intercept = cfg_mon.data;
          REG_AR_FIRST:   settings.ar_weight_first = cfg_mon.data;
          REG_AR_SECOND:  settings.ar_weight_second = cfg_mon.data;
          REG_LAG_FIRST:  settings.lag_weight_first = cfg_mon.data;
          REG_LAG_SECOND: settings.lag_weight_second = cfg_mon.data;
          REG_TAU:        settings.quantile_level = cfg_mon.data[TAU_W-1:0];
          REG_START_Q:    settings.start_quantile = cfg_mon.data;
          REG_WARMUP:     settings.warmup_count = cfg_mon.data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (item_mon.valid && item_mon.ready) begin
        estimate_queue.push_back(filter_step(item_mon.observation, item_mon.lag_value_first,
                                             item_mon.lag_value_second,
                                             item_mon.warmup_value, item_mon.last_item));
      end
      pending_count_o = estimate_queue.size();
    end
  end

endmodule

`default_nettype wire

[tb/tb_caviar_quantile_filter_loss.sv]
// top of the quantile filter testbench: clock, reset, directed and random items,
// register writes between phases, random idling on both sides, watchdog and verdict
// depends on cqfl_pkg, cqfl_if, cqfl_result_check and caviar_quantile_filter_loss
`default_nettype none

module tb_caviar_quantile_filter_loss;
  timeunit 1ns;
  timeprecision 1ps;
  import cqfl_pkg::*;

  localparam int unsigned AR_TAPS           = AR_TAPS_DEF;
  localparam int unsigned LAG_TAPS          = LAG_TAPS_DEF;
  localparam int unsigned CLK_PERIOD        = 2;
  localparam int unsigned RESET_CYCLES      = 11;
  localparam int unsigned WATCHDOG_LIMIT    = 1000;
  localparam int unsigned DRAIN_CYCLES      = 32;
  localparam int unsigned RANDOM_PHASES     = 9;
  localparam int unsigned PHASE_ITEMS       = 50;
  localparam int unsigned NO_IDLE_ITEMS     = 20;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        src_idle = 1'b0;
  logic        sink_idle = 1'b0;
  int unsigned error_count;
  int unsigned pending_count;
  int unsigned quiet_cycles = 0;

  cqfl_item_if   item_ch ();
  cqfl_result_if result_ch ();
  cqfl_cfg_if    cfg_ch ();

  caviar_quantile_filter_loss #(
    .AR_TAPS  (AR_TAPS),
    .LAG_TAPS (LAG_TAPS)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  cqfl_result_check #(
    .AR_TAPS  (AR_TAPS),
    .LAG_TAPS (LAG_TAPS)
  ) filter_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_mon        (item_ch),
    .result_mon      (result_ch),
    .cfg_mon         (cfg_ch),
    .error_count_o   (error_count),
    .pending_count_o (pending_count)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  function automatic logic signed [DATA_W-1:0] pick_sample();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = Q_MIN;
          1: v = Q_MAX;
          2: v = '0;
          3: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      1, 2: v = $urandom;
      default: v = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_weight();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = ($urandom_range(0, 1) == 0) ? Q_MIN : Q_MAX;
      1: v = $urandom;
      default: v = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
    endcase
    return v;
  endfunction

  task automatic send_item(input logic signed [DATA_W-1:0] obs,
                           input logic signed [DATA_W-1:0] lag1,
                           input logic signed [DATA_W-1:0] lag2,
                           input logic signed [DATA_W-1:0] warm,
                           input logic last_flag);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.observation <= obs;
    item_ch.lag_value_first <= lag1;
    item_ch.lag_value_second <= lag2;
    item_ch.warmup_value <= warm;
    item_ch.last_item <= last_flag;
    do @(posedge clk_i); while (!(item_ch.valid && item_ch.ready));
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // drop valid and wait until every result item is back
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = sink_idle ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(result_ch.valid && result_ch.ready));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("caviar_quantile_filter_loss: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned             phase;
    int unsigned             sent;
    int unsigned             k;
    int unsigned             series_len;
    logic                    last_flag;
    logic [TAU_W-1:0]        tau_word;
    logic [CNT_W-1:0]        warm_len;
    rst_ni = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.observation = '0;
    item_ch.lag_value_first = '0;
    item_ch.lag_value_second = '0;
    item_ch.warmup_value = '0;
    item_ch.last_item = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // register defaults: warm-up of two, then recursion with zero weights
    src_idle = 1'b1;
    sink_idle = 1'b1;
    send_item(Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b0);
    send_item(Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b0);
    send_item('0, Q_MIN, Q_MAX, 32'sd12345, 1'b1);
    settle();

    // zero warm-up, tau above one, stray register indexes
    write_reg(REG_INTERCEPT, Q_ONE);
    write_reg(REG_AR_FIRST, 32'h0000_8000);
    write_reg(REG_AR_SECOND, 32'hFFFF_8000);
    write_reg(REG_LAG_FIRST, 32'h0002_0000);
    write_reg(REG_LAG_SECOND, Q_MIN);
    write_reg(REG_TAU, 32'h0001_FFFF);
    write_reg(REG_START_Q, Q_MAX);
    write_reg(REG_WARMUP, 32'hFFFF_0000);
    write_reg(REG_WARMUP + CFG_IDX_W'(1), $urandom);
    write_reg({CFG_IDX_W{1'b1}}, $urandom);
    send_item(Q_MAX, Q_ONE, Q_MIN, Q_MAX, 1'b0);
    send_item(Q_MIN, Q_MAX, Q_MAX, '0, 1'b0);
    send_item(32'sd65536, -Q_ONE, 32'sd1, '0, 1'b0);
    send_item('0, '0, -32'sd1, Q_MIN, 1'b0);
    send_item(Q_MAX, Q_MIN, Q_MIN, '0, 1'b1);
    settle();

    // extreme weights, tau zero, warm-up shorter than the ar taps
    write_reg(REG_INTERCEPT, Q_MIN);
    write_reg(REG_AR_FIRST, Q_MAX);
    write_reg(REG_AR_SECOND, Q_MIN);
    write_reg(REG_LAG_FIRST, Q_MAX);
    write_reg(REG_LAG_SECOND, Q_MAX);
    write_reg(REG_TAU, '0);
    write_reg(REG_START_Q, Q_MIN);
    write_reg(REG_WARMUP, 32'h0000_0001);
    send_item(Q_MAX, '0, '0, Q_MIN, 1'b0);
    send_item(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0);
    send_item(-32'sd1, 32'sd1, -32'sd1, '0, 1'b0);
    send_item(Q_MAX, Q_MIN, Q_MIN, '0, 1'b0);
    send_item('0, '0, '0, '0, 1'b1);
    settle();

    // zero residual, both residual signs, rounding of half steps
    write_reg(REG_INTERCEPT, Q_ONE);
    write_reg(REG_AR_FIRST, 32'h0000_8000);
    write_reg(REG_AR_SECOND, 32'hFFFF_C000);
    write_reg(REG_LAG_FIRST, Q_ONE);
    write_reg(REG_LAG_SECOND, -Q_ONE);
    write_reg(REG_TAU, 32'd16384);
    write_reg(REG_START_Q, 32'h0002_0000);
    write_reg(REG_WARMUP, 32'd3);
    send_item(32'sh0007_0000, 32'sh0001_0000, 32'sh0003_0000, 32'sh0005_0000, 1'b0);
    send_item(32'sh0010_0000, 32'sh0000_0001, -32'sd1, 32'sh0000_0003, 1'b0);
    send_item(-32'sh0010_0000, 32'sh0000_8001, 32'sh0000_7FFF, 32'sh0000_0001, 1'b0);
    send_item(32'sh0003_0000, 32'sh0001_8000, -32'sh0000_8000, '0, 1'b0);
    send_item(-32'sh0000_0003, 32'sh0000_0003, 32'sh0000_0005, '0, 1'b1);
    settle();

    // series with no idling on either side, warm-up held throughout, tau one
    src_idle = 1'b0;
    sink_idle = 1'b0;
    write_reg(REG_INTERCEPT, pick_weight());
    write_reg(REG_AR_FIRST, pick_weight());
    write_reg(REG_AR_SECOND, pick_weight());
    write_reg(REG_LAG_FIRST, pick_weight());
    write_reg(REG_LAG_SECOND, pick_weight());
    write_reg(REG_TAU, DATA_W'(ONE_Q16));
    write_reg(REG_START_Q, '0);
    write_reg(REG_WARMUP, DATA_W'(CNT_MAX));
    for (k = 0; k < NO_IDLE_ITEMS; k++) begin
      send_item(Q_MAX, pick_sample(), pick_sample(), Q_MIN, k == NO_IDLE_ITEMS - 1);
    end
    settle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      src_idle = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 5))
        0: tau_word = '0;
        1: tau_word = ONE_Q16;
        2: tau_word = TAU_W'($urandom_range(65537, 131071));
        default: tau_word = TAU_W'($urandom_range(0, 65536));
      endcase
      warm_len = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 4));
      write_reg(REG_INTERCEPT, pick_weight());
      write_reg(REG_AR_FIRST, pick_weight());
      write_reg(REG_AR_SECOND, pick_weight());
      write_reg(REG_LAG_FIRST, pick_weight());
      write_reg(REG_LAG_SECOND, pick_weight());
      write_reg(REG_TAU, {(DATA_W-TAU_W)'($urandom), tau_word});
      write_reg(REG_START_Q, pick_sample());
      write_reg(REG_WARMUP, {(DATA_W-CNT_W)'($urandom), warm_len});
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_WARMUP + CFG_IDX_W'($urandom_range(1, 8)), $urandom);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        series_len = $urandom_range(1, 12);
        for (k = 0; k < series_len && sent < PHASE_ITEMS; k++) begin
          last_flag = (k == series_len - 1) || ($urandom_range(0, 19) == 0);
          send_item(pick_sample(), pick_sample(), pick_sample(), pick_sample(), last_flag);
          sent++;
        end
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("caviar_quantile_filter_loss: match");
    end else begin
      $display("caviar_quantile_filter_loss: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

[caviar_quantile_filter_loss.f]
+incdir+rtl
rtl/cqfl_pkg.sv
rtl/cqfl_if.sv
rtl/cqfl_cfg.sv
rtl/cqfl_mul.sv
rtl/caviar_quantile_filter_loss.sv
tb/cqfl_result_check.sv
tb/tb_caviar_quantile_filter_loss.sv
